// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
// Holds macro definitions only and depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_PROP(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside of reset.
`define ASSERT_NEVER(label, clk, rstn, cond, msg) \
  `ASSERT_PROP(label, clk, rstn, !(cond), msg)

`endif

// ----- design/gpcd_pkg.sv -----
// Types, widths and code constants of the position code decoder.
// Used by the decode logic, the top level and the checker.
package gpcd_pkg;

  localparam int NumOctets  = 9;
  localparam int OctetW     = 8;
  localparam int LatW       = 21;
  localparam int LonW       = 22;
  localparam int InTdataW   = NumOctets * OctetW;
  localparam int OutTdataW  = ((LatW + LonW + 7) / 8) * 8;

  localparam int UnitsPerDegree = 6000;
  localparam int MinuteUnits    = 100;
  localparam int LatLimit       = 540000;
  localparam int LonLimit       = 1080000;

  localparam logic [3:0] NibNorth  = 4'h5;
  localparam logic [3:0] NibSouth  = 4'h3;
  localparam logic [3:0] TableFar  = 4'h5;
  localparam logic [3:0] TableNear = 4'h3;
  localparam logic [3:0] NibWest   = 4'h5;
  localparam logic [3:0] NibEast   = 4'h3;

  localparam logic [7:0] DegLowFirst  = 8'h76;
  localparam logic [7:0] DegLowLast   = 8'h7E;
  localparam logic [7:0] DegMidFirst  = 8'h6C;
  localparam logic [7:0] DegMidLast   = 8'h74;
  localparam logic [7:0] DegHighFirst = 8'h26;
  localparam logic [7:0] DegHighLast  = 8'h6A;
  localparam logic [7:0] MinLowFirst  = 8'h58;
  localparam logic [7:0] MinLowLast   = 8'h61;
  localparam logic [7:0] MinHighFirst = 8'h26;
  localparam logic [7:0] MinHighLast  = 8'h57;
  localparam logic [7:0] HundFirst    = 8'h1C;
  localparam logic [7:0] HundLast     = 8'h7E;

  typedef logic [NumOctets-1:0][OctetW-1:0] octets_t;

  typedef struct packed {
    logic            position_valid;
    logic [LonW-1:0] longitude;
    logic [LatW-1:0] latitude;
  } result_t;

endpackage

// ----- design/gpcd_decode.sv -----
// Combinational decode of one nine-octet position code into a result.
// Depends on gpcd_pkg for the octet and result types and the code constants.
module gpcd_decode (
  input  gpcd_pkg::octets_t octets_i,
  output gpcd_pkg::result_t result_o
);
  import gpcd_pkg::*;

  logic [5:0][3:0] digits;
  logic            bcd_ok;
  logic [6:0]      lat_deg;
  logic [19:0]     lat_deg_part;
  logic [13:0]     lat_min_part;
  logic [19:0]     lat_mag;
  logic [LatW-1:0] lat_pos;
  logic [LatW-1:0] lat_neg;
  logic [3:0]      lat_flag;
  logic [3:0]      table_sel;
  logic [3:0]      lon_flag;
  logic [7:0]      deg_code;
  logic [7:0]      min_code;
  logic [7:0]      hund_code;
  logic [7:0]      lon_deg;
  logic [5:0]      lon_min;
  logic [6:0]      lon_hund;
  logic            deg_ok;
  logic            min_ok;
  logic            hund_ok;
  logic [20:0]     lon_mag;
  logic [LonW-1:0] lon_pos;
  logic [LonW-1:0] lon_neg;
  logic            flags_ok;
  logic            range_ok;
  logic            valid;

  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < 6; i++) begin
      digits[i] = octets_i[i][3:0];
      if (digits[i] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  assign lat_deg      = 7'(digits[0]) * 7'd10 + 7'(digits[1]);
  assign lat_deg_part = 20'(lat_deg) * 20'(UnitsPerDegree);
  assign lat_min_part = 14'(digits[2]) * 14'd1000 + 14'(digits[3]) * 14'd100
                      + 14'(digits[4]) * 14'd10 + 14'(digits[5]);
  assign lat_mag      = lat_deg_part + 20'(lat_min_part);
  assign lat_pos      = {1'b0, lat_mag};
  assign lat_neg      = LatW'(~lat_pos + 1'b1);

  assign lat_flag  = octets_i[3][7:4];
  assign table_sel = octets_i[4][7:4];
  assign lon_flag  = octets_i[5][7:4];
  assign deg_code  = octets_i[6];
  assign min_code  = octets_i[7];
  assign hund_code = octets_i[8];

  always_comb begin
    deg_ok  = 1'b1;
    lon_deg = '0;
    if (table_sel == TableFar) begin
      if (deg_code inside {[DegLowFirst:DegLowLast]}) begin
        lon_deg = deg_code - DegLowFirst;
      end else if (deg_code inside {[DegMidFirst:DegMidLast]}) begin
        lon_deg = deg_code - DegMidFirst + 8'd100;
      end else if (deg_code inside {[DegHighFirst:DegHighLast]}) begin
        lon_deg = deg_code - DegHighFirst + 8'd110;
      end else begin
        deg_ok = 1'b0;
      end
    end else if (table_sel == TableNear) begin
      if (deg_code inside {[DegHighFirst:DegLowLast]}) begin
        lon_deg = deg_code - DegHighFirst + 8'd10;
      end else begin
        deg_ok = 1'b0;
      end
    end else begin
      deg_ok = 1'b0;
    end
  end

  always_comb begin
    min_ok  = 1'b1;
    lon_min = '0;
    if (min_code inside {[MinLowFirst:MinLowLast]}) begin
      lon_min = 6'(min_code - MinLowFirst);
    end else if (min_code inside {[MinHighFirst:MinHighLast]}) begin
      lon_min = 6'(min_code - MinHighFirst + 8'd10);
    end else begin
      min_ok = 1'b0;
    end
  end

  always_comb begin
    hund_ok  = 1'b1;
    lon_hund = '0;
    if (hund_code inside {[HundFirst:HundLast]}) begin
      lon_hund = 7'(hund_code - HundFirst);
    end else begin
      hund_ok = 1'b0;
    end
  end

  assign lon_mag = 21'(lon_deg) * 21'(UnitsPerDegree) + 21'(lon_min) * 21'(MinuteUnits)
                 + 21'(lon_hund);
  assign lon_pos = {1'b0, lon_mag};
  assign lon_neg = LonW'(~lon_pos + 1'b1);

  assign flags_ok = ((lat_flag == NibNorth) || (lat_flag == NibSouth))
                 && ((lon_flag == NibWest) || (lon_flag == NibEast));
  assign range_ok = (lat_mag <= 20'(LatLimit)) && (lon_mag <= 21'(LonLimit));
  assign valid    = bcd_ok && flags_ok && deg_ok && min_ok && hund_ok && range_ok;

  always_comb begin
    result_o.position_valid = valid;
    result_o.latitude       = '0;
    result_o.longitude      = '0;
    if (valid) begin
      result_o.latitude  = (lat_flag == NibSouth) ? lat_neg : lat_pos;
      result_o.longitude = (lon_flag == NibWest) ? lon_neg : lon_pos;
    end
  end

endmodule

// ----- design/gps_position_code_decoder_core.sv -----
// Decodes nine-octet position codes into signed latitude and longitude, one item per clock
// while the output is not stalled. An item accepted on the input stream is held in the input
// register, and its result in the result register; the decode logic between the two sets the
// clock rate. Results are in 1/6000 degree, north and east positive, and are zero with tuser
// low when any code or range check fails.
// Depends on gpcd_pkg and gpcd_decode.
module gps_position_code_decoder_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // Octets 0 to 8, octet 0 in bits 7:0.
  input  logic [gpcd_pkg::InTdataW-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // Latitude in bits 20:0, longitude in bits 42:21, zero padding above.
  output logic [gpcd_pkg::OutTdataW-1:0]  m_axis_tdata_o,
  // Position valid flag.
  output logic                            m_axis_tuser_o
);
  import gpcd_pkg::*;

  octets_t in_q;
  logic    in_valid_q;
  logic    in_valid_d;
  result_t res_d;
  result_t res_q;
  logic    out_valid_q;
  logic    out_valid_d;
  logic    stage_adv;
  logic    in_fire;

  assign stage_adv       = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || stage_adv;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d  = s_axis_tready_o ? s_axis_tvalid_i : in_valid_q;
  assign out_valid_d = stage_adv ? in_valid_q : out_valid_q;

  gpcd_decode u_decode (
    .octets_i (in_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= s_axis_tdata_i;
    end
    if (stage_adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.position_valid;
  assign m_axis_tdata_o  = {(OutTdataW - LatW - LonW)'(0), res_q.longitude, res_q.latitude};

endmodule

// ----- design/gpcd_checker.sv -----
// Port-level checker for the position code decoder, bound to the top level.
// Depends on gpcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gpcd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [gpcd_pkg::OutTdataW-1:0]  m_axis_tdata_o,
  input logic                            m_axis_tuser_o
);
  import gpcd_pkg::*;

  localparam logic signed [LatW-1:0] LatMax = LatW'(LatLimit);

  logic                   in_fire;
  logic                   out_stall;
  logic                   invalid_nonzero;
  logic signed [LatW-1:0] lat_field;
  logic                   lat_in_range;
  logic [OutTdataW+1:0]   out_word;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall       = m_axis_tvalid_o && !m_axis_tready_i;
  assign invalid_nonzero = m_axis_tvalid_o && !m_axis_tuser_o && (m_axis_tdata_o != '0);
  assign lat_field       = $signed(m_axis_tdata_o[LatW-1:0]);
  assign lat_in_range    = (lat_field <= LatMax) && (lat_field >= -LatMax);
  assign out_word        = {m_axis_tvalid_o, m_axis_tuser_o, m_axis_tdata_o};

  `ASSERT_NEVER(a_invalid_zero, clk_i, rst_ni, invalid_nonzero, "Invalid result is nonzero.")
  `ASSERT_PROP(a_lat_bound, clk_i, rst_ni, m_axis_tvalid_o |-> lat_in_range, "Latitude too big.")
  `ASSERT_PROP(a_latency, clk_i, rst_ni, in_fire ##1 m_axis_tready_i |=> m_axis_tvalid_o, "Late.")
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_stall |=> $stable(out_word), "Stalled item changed.")

endmodule

bind gps_position_code_decoder_core gpcd_checker u_gpcd_checker (.*);

// ----- bench/tb_top.sv -----
// Self-checking bench for gps_position_code_decoder_core: directed and random position codes,
// expected fixes computed by an in-bench decoder and compared with each result item.
// Depends on gpcd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import gpcd_pkg::*;

  localparam int StuckLimit = 2000;
  localparam int HoldCycles = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_valid = 1'b0;
  logic [InTdataW-1:0]  s_data = '0;
  logic                 m_ready = 1'b0;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 m_axis_tuser_o;

  result_t pending_fixes[$];
  result_t want;
  int      mismatch_count = 0;
  int      src_idle_pct = 0;
  int      sink_idle_pct = 0;
  bit      hold_request = 1'b0;
  int      hold_left = 0;
  int      stuck_cycles = 0;

  gps_position_code_decoder_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic result_t decode_position(input octets_t c);
    result_t    r;
    logic [3:0] dig [6];
    int         lat;
    int         lon;
    int         deg;
    int         mins;
    int         hund;
    bit         ok;
    ok = 1'b1;
    deg = 0;
    mins = 0;
    hund = 0;
    for (int i = 0; i < 6; i++) begin
      dig[i] = c[i][3:0];
      if (dig[i] > 4'd9) ok = 1'b0;
    end
    lat = (int'(dig[0]) * 10 + int'(dig[1])) * UnitsPerDegree + int'(dig[2]) * 1000
        + int'(dig[3]) * 100 + int'(dig[4]) * 10 + int'(dig[5]);
    if (c[3][7:4] == NibSouth) lat = -lat;
    else if (c[3][7:4] != NibNorth) ok = 1'b0;

    if (c[4][7:4] == TableFar) begin
      if (c[6] >= DegLowFirst && c[6] <= DegLowLast) begin
        deg = int'(c[6]) - int'(DegLowFirst);
      end else if (c[6] >= DegMidFirst && c[6] <= DegMidLast) begin
        deg = 100 + int'(c[6]) - int'(DegMidFirst);
      end else if (c[6] >= DegHighFirst && c[6] <= DegHighLast) begin
        deg = 110 + int'(c[6]) - int'(DegHighFirst);
      end else begin
        ok = 1'b0;
      end
    end else if (c[4][7:4] == TableNear) begin
      if (c[6] >= DegHighFirst && c[6] <= DegLowLast) deg = 10 + int'(c[6]) - int'(DegHighFirst);
      else ok = 1'b0;
    end else begin
      ok = 1'b0;
    end

    if (c[7] >= MinLowFirst && c[7] <= MinLowLast) mins = int'(c[7]) - int'(MinLowFirst);
    else if (c[7] >= MinHighFirst && c[7] <= MinHighLast) begin
      mins = 10 + int'(c[7]) - int'(MinHighFirst);
    end else ok = 1'b0;

    if (c[8] >= HundFirst && c[8] <= HundLast) hund = int'(c[8]) - int'(HundFirst);
    else ok = 1'b0;

    lon = deg * UnitsPerDegree + mins * MinuteUnits + hund;
    if (c[5][7:4] == NibWest) lon = -lon;
    else if (c[5][7:4] != NibEast) ok = 1'b0;

    if (lat > LatLimit || lat < -LatLimit) ok = 1'b0;
    if (lon > LonLimit || lon < -LonLimit) ok = 1'b0;
    if (!ok) begin
      lat = 0;
      lon = 0;
    end
    r.position_valid = ok;
    r.latitude = lat[LatW-1:0];
    r.longitude = lon[LonW-1:0];
    return r;
  endfunction

  function automatic octets_t code_of(input logic [7:0] b0, b1, b2, b3, b4, b5, b6, b7, b8);
    octets_t c;
    c[0] = b0; c[1] = b1; c[2] = b2; c[3] = b3; c[4] = b4;
    c[5] = b5; c[6] = b6; c[7] = b7; c[8] = b8;
    return c;
  endfunction

  // Mostly well-formed codes with random digits and flags; the rest has one octet
  // overwritten or is fully random.
  function automatic octets_t random_code();
    octets_t c;
    int      kind;
    kind = $urandom_range(99);
    for (int i = 0; i < NumOctets; i++) c[i] = 8'($urandom);
    if (kind < 90) begin
      for (int i = 0; i < 6; i++) c[i][3:0] = 4'($urandom_range(9));
      c[3][7:4] = $urandom_range(1) ? NibNorth : NibSouth;
      c[4][7:4] = $urandom_range(1) ? TableFar : TableNear;
      c[5][7:4] = $urandom_range(1) ? NibWest : NibEast;
      if (c[4][7:4] == TableFar) begin
        case ($urandom_range(2))
          0: c[6] = 8'($urandom_range(DegLowLast, DegLowFirst));
          1: c[6] = 8'($urandom_range(DegMidLast, DegMidFirst));
          default: c[6] = 8'($urandom_range(DegHighLast, DegHighFirst));
        endcase
      end else begin
        c[6] = 8'($urandom_range(DegLowLast, DegHighFirst));
      end
      c[7] = 8'($urandom_range(MinLowLast, MinHighFirst));
      c[8] = 8'($urandom_range(HundLast, HundFirst));
      if (kind >= 80) c[$urandom_range(NumOctets - 1)] = 8'($urandom);
    end
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic offer_code(input octets_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= c;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_fixes.push_back(decode_position(c));
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    src_idle_pct = 16;
    sink_idle_pct = 73;
    // Zero latitude, far table at degree 0, minutes code 0x58 as zero minutes.
    offer_code(code_of(8'h30, 8'h30, 8'h30, 8'h50, 8'h50, 8'h30, 8'h76, 8'h58, 8'h1C));
    // Exactly 90 degrees is valid; one hundredth more is not; 91 degrees is not.
    offer_code(code_of(8'h39, 8'h30, 8'h30, 8'h50, 8'h30, 8'h50, 8'h26, 8'h26, 8'h1C));
    offer_code(code_of(8'h39, 8'h30, 8'h30, 8'h50, 8'h30, 8'h51, 8'h26, 8'h26, 8'h1C));
    offer_code(code_of(8'h39, 8'h31, 8'h30, 8'h30, 8'h30, 8'h30, 8'h26, 8'h26, 8'h1C));
    // Large magnitudes: 89 59.99 south and the largest longitude, 178 59.98 east.
    offer_code(code_of(8'h38, 8'h39, 8'h35, 8'h39, 8'h59, 8'h39, 8'h6A, 8'h57, 8'h7E));
    // Far table range edges and the gaps between them.
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h55, 8'h56, 8'h7E, 8'h61, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h55, 8'h36, 8'h6C, 8'h61, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h55, 8'h56, 8'h74, 8'h61, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h55, 8'h36, 8'h26, 8'h61, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h55, 8'h36, 8'h75, 8'h61, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h55, 8'h36, 8'h6B, 8'h61, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h55, 8'h36, 8'h7F, 8'h61, 8'h50));
    // Near table edges.
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h56, 8'h7E, 8'h61, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h56, 8'h25, 8'h61, 8'h50));
    // Minutes and hundredths out of range.
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h35, 8'h36, 8'h50, 8'h62, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h35, 8'h36, 8'h50, 8'h25, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h35, 8'h36, 8'h50, 8'h40, 8'h1B));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h35, 8'h36, 8'h50, 8'h40, 8'h7F));
    // Bad BCD digits.
    offer_code(code_of(8'h3A, 8'h32, 8'h33, 8'h54, 8'h35, 8'h36, 8'h50, 8'h40, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h35, 8'h3F, 8'h50, 8'h40, 8'h50));
    // Unknown hemisphere and table flags.
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h44, 8'h35, 8'h36, 8'h50, 8'h40, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h05, 8'h36, 8'h50, 8'h40, 8'h50));
    offer_code(code_of(8'h31, 8'h32, 8'h33, 8'h54, 8'h35, 8'hF6, 8'h50, 8'h40, 8'h50));
    offer_code(code_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    offer_code(code_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_random(input int count, input int src_pct, input int sink_pct);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) offer_code(random_code());
  endtask

  // The receiver stops for a long stretch while codes keep coming, so the input stalls.
  task automatic test_backpressure(input int count);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    s_valid <= 1'b0;
    @(posedge clk_i);
    hold_request = 1'b1;
    @(negedge clk_i);
    repeat (count) offer_code(random_code());
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_fixes.size() == 0) begin
        $error("result item with no pending code: tdata %h tuser %b",
               m_axis_tdata_o, m_axis_tuser_o);
        mismatch_count++;
      end else begin
        want = pending_fixes.pop_front();
        if (m_axis_tuser_o !== want.position_valid) begin
          $error("position_valid: expected %0d, actual %0d", want.position_valid,
                 m_axis_tuser_o);
          mismatch_count++;
        end
        if (m_axis_tdata_o[LatW-1:0] !== want.latitude) begin
          $error("latitude: expected %0d, actual %0d", $signed(want.latitude),
                 $signed(m_axis_tdata_o[LatW-1:0]));
          mismatch_count++;
        end
        if (m_axis_tdata_o[LatW+LonW-1:LatW] !== want.longitude) begin
          $error("longitude: expected %0d, actual %0d", $signed(want.longitude),
                 $signed(m_axis_tdata_o[LatW+LonW-1:LatW]));
          mismatch_count++;
        end
        if (m_axis_tdata_o[OutTdataW-1:LatW+LonW] !== '0) begin
          $error("padding: expected 0, actual %h", m_axis_tdata_o[OutTdataW-1:LatW+LonW]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      stuck_cycles = 0;
    end else if (s_valid || pending_fixes.size() != 0) begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(650, 16, 73);
    test_random(650, 73, 16);
    test_backpressure(60);
    test_random(600, 0, 0);
    s_valid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/gpcd_pkg.sv
design/gpcd_decode.sv
design/gps_position_code_decoder_core.sv
design/gpcd_checker.sv
bench/tb_top.sv
